// File: hw/rtl/assert_macros.svh
// Assertion helpers for the connection table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on clk, held off during reset.
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant on clk, held off during reset.
`define CHK_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// File: hw/rtl/lcpt_pkg.sv
`default_nettype none
package lcpt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_W = 64;
    localparam int TIME_W = 64;
    localparam int CFG_W = 5;

    typedef enum logic [2:0] {
        MODE_BEGIN       = 3'd0,
        MODE_CONNECTING  = 3'd1,
        MODE_ESTABLISHED = 3'd2,
        MODE_FAILED      = 3'd3,
        MODE_TOUCH       = 3'd4,
        MODE_REMOVE      = 3'd5,
        MODE_QUERY       = 3'd6
    } mode_t;

    localparam logic [1:0] ST_REQUESTED   = 2'd0;
    localparam logic [1:0] ST_CONNECTING  = 2'd1;
    localparam logic [1:0] ST_ESTABLISHED = 2'd2;
    localparam logic [1:0] ST_FAILED      = 2'd3;

    localparam logic CFG_INFLIGHT_LIM = 1'b0;
    localparam logic CFG_ENDPOINT_LIM = 1'b1;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [KEY_W-1:0]  conn_key;
        logic [TIME_W-1:0] now_time;
    } req_t;

    typedef struct packed {
        logic              accepted;
        logic              evicted_valid;
        logic [KEY_W-1:0]  evicted_key;
        logic              found;
        logic [1:0]        entry_state;
        logic [4:0]        entry_count;
        logic [4:0]        in_flight_count;
    } rsp_t;

    // Fixed-width part of the record that walks the cell row
    typedef struct packed {
        logic              match;
        logic [1:0]        match_state;
        logic              free;
        logic              lru;
        logic [TIME_W-1:0] lru_time;
        logic [KEY_W-1:0]  lru_key;
    } scan_t;

    // Per-cell update command
    typedef struct packed {
        logic       wr_new;
        logic       clr;
        logic       set_state;
        logic [1:0] new_state;
        logic       set_time;
    } cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/lru_connection_pool_table_unit.sv
`default_nettype none
// Keyed connection table with LRU replacement of established entries.
// Request channel: in_valid/in_ready carry in_data (mode, conn_key, now_time).
// Response channel: out_valid/out_ready carry out_data, one response per
// request, in request order.
// Config port: cfg_we with cfg_index (0 in-flight limit, 1 endpoint limit)
// and cfg_wdata; the user must write only while no request is outstanding.
// The block does not enforce this. Each slot lives in one cell of a row of
// TABLE_DEPTH cells. A request is answered by a scan record that steps one
// cell per cycle, gathering the key match, the first free slot, the LRU
// established slot and both counts. The result passes through start_reg, the
// cell registers and the held result registers before the response is
// loaded; the slot update lands in the cycle after. A new request is accepted
// only once the previous scan has finished and its response is loaded.
// A request may be accepted while the previous response still waits; when
// the receiver stalls, the finished scan waits in the done state and the
// table stays untouched until the response register frees up.
// Reset empties every slot and sets both limits to 16; no clearing pass.
module lru_connection_pool_table_unit #(
    parameter int TABLE_DEPTH = lcpt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire lcpt_pkg::req_t             in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output lcpt_pkg::rsp_t                  out_data,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [lcpt_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    lcpt_pkg::fsm_t state_reg, state_next;

    logic [lcpt_pkg::CFG_W-1:0] max_if_reg, max_ep_reg;
    lcpt_pkg::req_t             req_reg;
    logic                       start_reg;

    // Chain wiring: element i feeds cell i
    logic            c_vld [TABLE_DEPTH+1];
    lcpt_pkg::scan_t c_rec [TABLE_DEPTH+1];
    logic [IDX_W-1:0] c_midx [TABLE_DEPTH+1];
    logic [IDX_W-1:0] c_fidx [TABLE_DEPTH+1];
    logic [IDX_W-1:0] c_lidx [TABLE_DEPTH+1];
    logic [CNT_W-1:0] c_cv [TABLE_DEPTH+1];
    logic [CNT_W-1:0] c_cif [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0] chain_vld_vec;

    // Held result of the finished scan
    lcpt_pkg::scan_t  h_rec_reg;
    logic [IDX_W-1:0] h_midx_reg, h_fidx_reg, h_lidx_reg;
    logic [CNT_W-1:0] h_cv_reg, h_cif_reg;

    lcpt_pkg::cmd_t cmd_reg [TABLE_DEPTH];
    lcpt_pkg::cmd_t cmd_next [TABLE_DEPTH];

    logic           out_valid_reg;
    lcpt_pkg::rsp_t out_reg, rsp;

    logic fire, in_acc;

    // Decision terms
    logic             do_new, do_clr, do_state, do_time, need_ev;
    logic [1:0]       st_val;
    logic [IDX_W-1:0] new_idx, clr_idx;
    logic [CNT_W-1:0] cv_after, cif_after;
    logic             old_if;

    assign in_ready  = (state_reg == lcpt_pkg::FSM_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign fire      = (state_reg == lcpt_pkg::FSM_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Config registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            max_if_reg <= 5'd16;
            max_ep_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcpt_pkg::CFG_INFLIGHT_LIM: max_if_reg <= cfg_wdata;
                lcpt_pkg::CFG_ENDPOINT_LIM: max_ep_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // FSM next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lcpt_pkg::FSM_IDLE: if (in_acc) state_next = lcpt_pkg::FSM_SCAN;
            lcpt_pkg::FSM_SCAN: if (c_vld[TABLE_DEPTH]) state_next = lcpt_pkg::FSM_DONE;
            lcpt_pkg::FSM_DONE: if (fire) state_next = lcpt_pkg::FSM_IDLE;
            default:            state_next = lcpt_pkg::FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= lcpt_pkg::FSM_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_acc;
        end
    end

    always_ff @(posedge clk) begin
        if (in_acc)
        begin
            req_reg <= in_data;
        end
        if (c_vld[TABLE_DEPTH])
        begin
            h_rec_reg  <= c_rec[TABLE_DEPTH];
            h_midx_reg <= c_midx[TABLE_DEPTH];
            h_fidx_reg <= c_fidx[TABLE_DEPTH];
            h_lidx_reg <= c_lidx[TABLE_DEPTH];
            h_cv_reg   <= c_cv[TABLE_DEPTH];
            h_cif_reg  <= c_cif[TABLE_DEPTH];
        end
    end

    // Chain head: an empty record
    assign c_vld[0]  = start_reg;
    assign c_rec[0]  = '0;
    assign c_midx[0] = '0;
    assign c_fidx[0] = '0;
    assign c_lidx[0] = '0;
    assign c_cv[0]   = '0;
    assign c_cif[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            lcpt_cell #(
                .IDX_W   (IDX_W),
                .CNT_W   (CNT_W),
                .CELL_IDX(g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .req_key      (req_reg.conn_key),
                .req_time     (req_reg.now_time),
                .cmd          (cmd_reg[g]),
                .in_vld       (c_vld[g]),
                .in_rec       (c_rec[g]),
                .in_match_idx (c_midx[g]),
                .in_free_idx  (c_fidx[g]),
                .in_lru_idx   (c_lidx[g]),
                .in_cnt_v     (c_cv[g]),
                .in_cnt_if    (c_cif[g]),
                .out_vld      (c_vld[g+1]),
                .out_rec      (c_rec[g+1]),
                .out_match_idx(c_midx[g+1]),
                .out_free_idx (c_fidx[g+1]),
                .out_lru_idx  (c_lidx[g+1]),
                .out_cnt_v    (c_cv[g+1]),
                .out_cnt_if   (c_cif[g+1])
            );
        end
        for (g = 0; g <= TABLE_DEPTH; g++)
        begin : g_vvec
            assign chain_vld_vec[g] = c_vld[g];
        end
    endgenerate

    // Operation decode on the finished scan
    always_comb begin
        do_new    = 1'b0;
        do_clr    = 1'b0;
        do_state  = 1'b0;
        do_time   = 1'b0;
        st_val    = lcpt_pkg::ST_REQUESTED;
        new_idx   = h_fidx_reg;
        clr_idx   = h_midx_reg;
        old_if    = h_rec_reg.match && !h_rec_reg.match_state[1];
        need_ev   = (32'(h_cv_reg) >= 32'(max_ep_reg)) || (32'(h_cv_reg) >= TABLE_DEPTH);
        cv_after  = h_cv_reg;
        cif_after = h_cif_reg;
        rsp                 = '0;
        rsp.found           = h_rec_reg.match;
        rsp.entry_state     = h_rec_reg.match ? h_rec_reg.match_state : lcpt_pkg::ST_REQUESTED;
        case (req_reg.mode)
            lcpt_pkg::MODE_BEGIN:
            begin
                if (h_rec_reg.match)
                begin
                    do_time      = 1'b1;
                    rsp.accepted = 1'b1;
                end
                else if ((32'(h_cif_reg) < 32'(max_if_reg)) && (!need_ev || h_rec_reg.lru))
                begin
                    if (need_ev)
                    begin
                        do_clr            = 1'b1;
                        clr_idx           = h_lidx_reg;
                        rsp.evicted_valid = 1'b1;
                        rsp.evicted_key   = h_rec_reg.lru_key;
                        cv_after          = h_cv_reg - CNT_W'(1);
                        if (!h_rec_reg.free || (h_lidx_reg < h_fidx_reg))
                        begin
                            new_idx = h_lidx_reg;
                        end
                    end
                    if (need_ev || h_rec_reg.free)
                    begin
                        do_new          = 1'b1;
                        rsp.accepted    = 1'b1;
                        rsp.entry_state = lcpt_pkg::ST_REQUESTED;
                        cv_after        = cv_after + CNT_W'(1);
                        cif_after       = h_cif_reg + CNT_W'(1);
                    end
                end
            end
            lcpt_pkg::MODE_CONNECTING:
            begin
                do_state = h_rec_reg.match;
                st_val   = lcpt_pkg::ST_CONNECTING;
                if (h_rec_reg.match)
                begin
                    rsp.entry_state = lcpt_pkg::ST_CONNECTING;
                    cif_after       = h_cif_reg - CNT_W'(old_if) + CNT_W'(1);
                end
            end
            lcpt_pkg::MODE_ESTABLISHED:
            begin
                do_state = h_rec_reg.match;
                do_time  = h_rec_reg.match;
                st_val   = lcpt_pkg::ST_ESTABLISHED;
                if (h_rec_reg.match)
                begin
                    rsp.entry_state = lcpt_pkg::ST_ESTABLISHED;
                    cif_after       = h_cif_reg - CNT_W'(old_if);
                end
            end
            lcpt_pkg::MODE_FAILED:
            begin
                do_state = h_rec_reg.match;
                st_val   = lcpt_pkg::ST_FAILED;
                if (h_rec_reg.match)
                begin
                    rsp.entry_state = lcpt_pkg::ST_FAILED;
                    cif_after       = h_cif_reg - CNT_W'(old_if);
                end
            end
            lcpt_pkg::MODE_TOUCH:
            begin
                do_time = h_rec_reg.match;
            end
            lcpt_pkg::MODE_REMOVE:
            begin
                do_clr          = h_rec_reg.match;
                rsp.entry_state = lcpt_pkg::ST_REQUESTED;
                if (h_rec_reg.match)
                begin
                    cv_after  = h_cv_reg - CNT_W'(1);
                    cif_after = h_cif_reg - CNT_W'(old_if);
                end
            end
            default: ;
        endcase
        rsp.entry_count     = (32'(cv_after) > 32'd31) ? 5'd31 : 5'(cv_after);
        rsp.in_flight_count = (32'(cif_after) > 32'd31) ? 5'd31 : 5'(cif_after);
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            cmd_next[j].wr_new    = fire && do_new && (new_idx == IDX_W'(j));
            cmd_next[j].clr       = fire && do_clr && (clr_idx == IDX_W'(j));
            cmd_next[j].set_state = fire && do_state && (h_midx_reg == IDX_W'(j));
            cmd_next[j].new_state = st_val;
            cmd_next[j].set_time  = fire && do_time && (h_midx_reg == IDX_W'(j));
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int j = 0; j < TABLE_DEPTH; j++)
            begin
                cmd_reg[j] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            for (int j = 0; j < TABLE_DEPTH; j++)
            begin
                cmd_reg[j] <= cmd_next[j];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (fire)
        begin
            out_reg <= rsp;
        end
    end

`include "assert_macros.svh"

    // Only one scan record may be in the row at a time
    `CHK_ALWAYS(a_one_token, $onehot0(chain_vld_vec), "more than one scan record in flight")
    // The row only finishes while a scan is expected
    `CHK_IMPL(a_end_in_scan, c_vld[TABLE_DEPTH], state_reg == lcpt_pkg::FSM_SCAN,
              "scan finished outside scan state")
    // In-flight entries are a subset of all entries
    `CHK_IMPL(a_counts, out_valid_reg, out_reg.in_flight_count <= out_reg.entry_count,
              "in-flight count exceeds entry count")

endmodule
`default_nettype wire

// File: hw/rtl/lcpt_cell.sv
`default_nettype none
module lcpt_cell #(
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lcpt_pkg::KEY_W-1:0] req_key,
    input  wire logic [lcpt_pkg::TIME_W-1:0] req_time,
    input  wire lcpt_pkg::cmd_t             cmd,
    input  wire logic                       in_vld,
    input  wire lcpt_pkg::scan_t            in_rec,
    input  wire logic [IDX_W-1:0]           in_match_idx,
    input  wire logic [IDX_W-1:0]           in_free_idx,
    input  wire logic [IDX_W-1:0]           in_lru_idx,
    input  wire logic [CNT_W-1:0]           in_cnt_v,
    input  wire logic [CNT_W-1:0]           in_cnt_if,
    output logic                            out_vld,
    output lcpt_pkg::scan_t                 out_rec,
    output logic [IDX_W-1:0]                out_match_idx,
    output logic [IDX_W-1:0]                out_free_idx,
    output logic [IDX_W-1:0]                out_lru_idx,
    output logic [CNT_W-1:0]                out_cnt_v,
    output logic [CNT_W-1:0]                out_cnt_if
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                        valid_reg;
    logic [lcpt_pkg::KEY_W-1:0]  key_reg;
    logic [1:0]                  state_reg;
    logic [lcpt_pkg::TIME_W-1:0] time_reg;

    logic                        vld_reg;
    lcpt_pkg::scan_t             rec_reg, rec_next;
    logic [IDX_W-1:0]            midx_reg, midx_next;
    logic [IDX_W-1:0]            fidx_reg, fidx_next;
    logic [IDX_W-1:0]            lidx_reg, lidx_next;
    logic [CNT_W-1:0]            cv_reg, cv_next;
    logic [CNT_W-1:0]            cif_reg, cif_next;

    logic hit, older;

    // Slot storage
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.wr_new)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd.clr)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.wr_new)
        begin
            key_reg   <= req_key;
            state_reg <= lcpt_pkg::ST_REQUESTED;
            time_reg  <= req_time;
        end
        else
        begin
            if (cmd.set_state)
            begin
                state_reg <= cmd.new_state;
            end
            if (cmd.set_time)
            begin
                time_reg <= req_time;
            end
        end
    end

    // Scan step for this slot
    always_comb begin
        hit   = valid_reg && (key_reg == req_key);
        older = !in_rec.lru || (time_reg < in_rec.lru_time) ||
                ((time_reg == in_rec.lru_time) && (key_reg < in_rec.lru_key));
        rec_next  = in_rec;
        midx_next = in_match_idx;
        fidx_next = in_free_idx;
        lidx_next = in_lru_idx;
        cv_next   = in_cnt_v + CNT_W'(valid_reg);
        cif_next  = in_cnt_if + CNT_W'(valid_reg && !state_reg[1]);
        if (hit)
        begin
            rec_next.match       = 1'b1;
            rec_next.match_state = state_reg;
            midx_next            = MY_IDX;
        end
        if (!valid_reg && !in_rec.free)
        begin
            rec_next.free = 1'b1;
            fidx_next     = MY_IDX;
        end
        if (valid_reg && (state_reg == lcpt_pkg::ST_ESTABLISHED) && older)
        begin
            rec_next.lru      = 1'b1;
            rec_next.lru_time = time_reg;
            rec_next.lru_key  = key_reg;
            lidx_next         = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk) begin
        rec_reg  <= rec_next;
        midx_reg <= midx_next;
        fidx_reg <= fidx_next;
        lidx_reg <= lidx_next;
        cv_reg   <= cv_next;
        cif_reg  <= cif_next;
    end

    assign out_vld       = vld_reg;
    assign out_rec       = rec_reg;
    assign out_match_idx = midx_reg;
    assign out_free_idx  = fidx_reg;
    assign out_lru_idx   = lidx_reg;
    assign out_cnt_v     = cv_reg;
    assign out_cnt_if    = cif_reg;

endmodule
`default_nettype wire
